/* rtl/rcse_pkg.sv */
// Package for the record cell size estimator: column kinds, queue entry and
// status types, size limits and the serial-size function.
// No dependencies.
`timescale 1ns / 1ps

package rcse_pkg;

   // Widths of the running sums and of one column's increments
   localparam int SUM_W      = 48;
   localparam int HDR_INC_W  = 4;
   localparam int DATA_INC_W = 31;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Magnitude limits of the serial-size rule
   localparam logic [63:0] SIZE_LIM_1 = 64'd128;
   localparam logic [63:0] SIZE_LIM_2 = 64'd32768;
   localparam logic [63:0] SIZE_LIM_3 = 64'd8388608;
   localparam logic [63:0] SIZE_LIM_4 = 64'd2147483648;
   localparam logic [63:0] SIZE_LIM_6 = 64'd140737488355328;

   // Header bias for text and blob columns
   localparam logic [63:0] TEXT_BIAS = 64'd12;
   localparam logic [63:0] BLOB_BIAS = 64'd13;

   typedef enum logic [2:0] {
      KIND_NULL    = 3'd0,
      KIND_INTEGER = 3'd1,
      KIND_FLOAT   = 3'd2,
      KIND_TEXT    = 3'd3,
      KIND_BLOB    = 3'd4
   } kind_type;

   // One classified column as it waits in the queue
   typedef struct packed {
      logic [HDR_INC_W-1:0]  hdr_inc;
      logic [DATA_INC_W-1:0] data_inc;
      logic                  last;
   } col_entry_type;

   // Fill status of the queue
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Bytes needed for a value; a negative value is sized by its complement.
   function automatic logic [HDR_INC_W-1:0] serial_size(input logic [63:0] raw);
      logic [63:0]          mag;
      logic [HDR_INC_W-1:0] res;
      mag = raw[63] ? ~raw : raw;
      if (mag < SIZE_LIM_1) begin
         res = 4'd1;
      end else if (mag < SIZE_LIM_2) begin
         res = 4'd2;
      end else if (mag < SIZE_LIM_3) begin
         res = 4'd3;
      end else if (mag < SIZE_LIM_4) begin
         res = 4'd4;
      end else if (mag < SIZE_LIM_6) begin
         res = 4'd6;
      end else begin
         res = 4'd8;
      end
      return res;
   endfunction

endpackage

/* rtl/rcse_front.sv */
// Front end of the record cell size estimator: takes column beats and turns
// each into header and data increments for the queue. Depends on rcse_pkg.
`timescale 1ns / 1ps

module rcse_front import rcse_pkg::*; (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_kind,
   input  logic [63:0]      req_int_value,
   input  logic [63:0]      req_float_bits,
   input  logic [30:0]      req_byte_length,
   input  logic             req_last_column,
   input  queue_status_type q_status,
   output logic             push,
   output col_entry_type    entry
);

   localparam logic [10:0] EXP_BIAS = 11'd1023;
   localparam logic [10:0] EXP_TOP  = 11'd1069;
   localparam logic [5:0]  EXP_LIM_1 = 6'd7;
   localparam logic [5:0]  EXP_LIM_2 = 6'd15;
   localparam logic [5:0]  EXP_LIM_3 = 6'd23;
   localparam logic [5:0]  EXP_LIM_4 = 6'd31;

   // Data bytes of a float. An integral value has magnitude in
   // [2^e, 2^(e+1)), so every size limit (a power of two) is decided by the
   // exponent. A negative value is sized from magnitude minus one, which
   // drops below a limit also when the magnitude equals that power exactly.
   function automatic logic [HDR_INC_W-1:0] float_data_bytes(input logic [63:0] bits);
      logic                 neg;
      logic [10:0]          bexp;
      logic [51:0]          mant;
      logic [5:0]           e;
      logic                 on_edge;
      logic [HDR_INC_W-1:0] res;
      neg     = bits[63];
      bexp    = bits[62:52];
      mant    = bits[51:0];
      e       = 6'(bexp - EXP_BIAS);
      on_edge = neg && (mant == '0);
      if (bexp == '0) begin
         res = (mant != '0) ? 4'd8 : 4'd0;
      end else if (bexp < EXP_BIAS || bexp > EXP_TOP) begin
         res = 4'd8;
      end else if ((mant & ({52{1'b1}} >> e)) != '0) begin
         res = 4'd8;
      end else if (!neg && e == '0) begin
         res = 4'd0;
      end else if (e < EXP_LIM_1 || (on_edge && e == EXP_LIM_1)) begin
         res = 4'd1;
      end else if (e < EXP_LIM_2 || (on_edge && e == EXP_LIM_2)) begin
         res = 4'd2;
      end else if (e < EXP_LIM_3 || (on_edge && e == EXP_LIM_3)) begin
         res = 4'd3;
      end else if (e < EXP_LIM_4 || (on_edge && e == EXP_LIM_4)) begin
         res = 4'd4;
      end else begin
         res = 4'd6;
      end
      return res;
   endfunction

   logic [63:0] twice_len;

   // Accept a beat whenever the queue has room
   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;
   assign twice_len = {32'd0, req_byte_length, 1'b0};

   // Classify the column
   always_comb begin
      entry.last     = req_last_column;
      entry.hdr_inc  = '0;
      entry.data_inc = '0;
      case (req_kind)
         KIND_NULL: begin
            entry.hdr_inc = 4'd1;
         end
         KIND_INTEGER: begin
            entry.hdr_inc = 4'd1;
            if (req_int_value[63:1] != '0) begin
               entry.data_inc = DATA_INC_W'(serial_size(req_int_value));
            end
         end
         KIND_FLOAT: begin
            entry.hdr_inc  = 4'd1;
            entry.data_inc = DATA_INC_W'(float_data_bytes(req_float_bits));
         end
         KIND_TEXT: begin
            entry.hdr_inc  = serial_size(twice_len + TEXT_BIAS);
            entry.data_inc = req_byte_length;
         end
         KIND_BLOB: begin
            entry.hdr_inc  = serial_size(twice_len + BLOB_BIAS);
            entry.data_inc = req_byte_length;
         end
         default: begin
            entry.hdr_inc  = '0;
            entry.data_inc = '0;
         end
      endcase
   end

endmodule

/* rtl/rcse_queue.sv */
// Short queue of classified columns between the front and back ends of the
// record cell size estimator. Depends on rcse_pkg.
`timescale 1ns / 1ps

module rcse_queue import rcse_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  col_entry_type    push_entry,
   input  logic             pop,
   output col_entry_type    pop_entry,
   output queue_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   col_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign pop_entry      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/rcse_back.sv */
// Back end of the record cell size estimator: running header and data sums
// and the pipelined total for the last column. Depends on rcse_pkg.
`timescale 1ns / 1ps

module rcse_back import rcse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   q_status,
   input  col_entry_type      col,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SUM_W-1:0]   rsp_record_size
);

   logic               advance;
   logic [SUM_W:0]     hdr_wide, data_wide;
   logic [SUM_W-1:0]   hdr_next, data_next;
   logic [SUM_W-1:0]   hdr_sum_ff, hdr_sum_in;
   logic [SUM_W-1:0]   data_sum_ff, data_sum_in;
   logic               s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0]   s2_hdr_ff, s2_data_ff;
   logic               s3_valid_ff;
   logic [SUM_W:0]     s3_hs_ff, s3_hs_in;
   logic [SUM_W:0]     s3_hd_ff, s3_hd_in;
   logic               s4_valid_ff;
   logic [HDR_INC_W-1:0] s4_size_ff, s4_size_in;
   logic [SUM_W:0]     s4_hd_ff;
   logic [SUM_W+1:0]   total_wide;
   logic [SUM_W-1:0]   total_in;
   logic               rsp_valid_ff;
   logic [SUM_W-1:0]   rsp_size_ff;

   // The whole pipeline moves unless a result waits untaken
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !q_status.empty;

   // Saturating accumulation of one column
   always_comb begin
      hdr_wide  = {1'b0, hdr_sum_ff} + (SUM_W + 1)'(col.hdr_inc);
      data_wide = {1'b0, data_sum_ff} + (SUM_W + 1)'(col.data_inc);
      hdr_next  = hdr_wide[SUM_W] ? SUM_MAX : hdr_wide[SUM_W-1:0];
      data_next = data_wide[SUM_W] ? SUM_MAX : data_wide[SUM_W-1:0];
      hdr_sum_in  = hdr_sum_ff;
      data_sum_in = data_sum_ff;
      s2_valid_in = 1'b0;
      if (pop) begin
         s2_valid_in = col.last;
         hdr_sum_in  = col.last ? '0 : hdr_next;
         data_sum_in = col.last ? '0 : data_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_sum_ff  <= '0;
         data_sum_ff <= '0;
      end else begin
         hdr_sum_ff  <= hdr_sum_in;
         data_sum_ff <= data_sum_in;
      end
   end

   // Header plus its own size, and header plus data
   assign s3_hs_in = {1'b0, s2_hdr_ff} + (SUM_W + 1)'(serial_size(64'(s2_hdr_ff)));
   assign s3_hd_in = {1'b0, s2_hdr_ff} + {1'b0, s2_data_ff};

   // Size of the extended header
   assign s4_size_in = serial_size(64'(s3_hs_ff));

   // Final saturating total
   assign total_wide = {1'b0, s4_hd_ff} + (SUM_W + 2)'(s4_size_ff);
   assign total_in   = (total_wide[SUM_W+1:SUM_W] != '0) ? SUM_MAX : total_wide[SUM_W-1:0];

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_hdr_ff   <= hdr_next;
         s2_data_ff  <= data_next;
         s3_hs_ff    <= s3_hs_in;
         s3_hd_ff    <= s3_hd_in;
         s4_size_ff  <= s4_size_in;
         s4_hd_ff    <= s3_hd_ff;
         rsp_size_ff <= total_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_record_size = rsp_size_ff;

endmodule

/* rtl/record_cell_size_estimator.sv */
// Record size estimator: one column beat per cycle, one result per row.
// Throughput is one column per clock while rsp_ready is high; the back
// pipeline and the queue both move one entry per cycle.
// A result shows on rsp_valid once its last column is taken and has passed
// the accumulate register, two sizing stages and the output register.
// Synchronous active-high reset empties the queue and clears both sums.
`timescale 1ns / 1ps

module record_cell_size_estimator import rcse_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_kind,
   input  logic [63:0]  req_int_value,
   input  logic [63:0]  req_float_bits,
   input  logic [30:0]  req_byte_length,
   input  logic         req_last_column,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [47:0]  rsp_record_size
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   col_entry_type    push_entry;
   col_entry_type    pop_entry;

   // Column classification
   rcse_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_int_value   (req_int_value),
      .req_float_bits  (req_float_bits),
      .req_byte_length (req_byte_length),
      .req_last_column (req_last_column),
      .q_status        (q_status),
      .push            (push),
      .entry           (push_entry)
   );

   // Decoupling queue
   rcse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // Accumulation and total
   rcse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .col             (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_record_size (rsp_record_size)
   );

endmodule

/* rtl/rcse_checker.sv */
// Port-level checks for the record cell size estimator, bound to the top
// level. Depends only on the top level's ports.
`timescale 1ns / 1ps

module rcse_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [47:0]  rsp_record_size
);

   // A stalled result beat holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_size))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending and the input side open
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   // Every row costs at least the byte that sizes its header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_record_size != 48'd0)
      else $error("zero record size reported");

endmodule

bind record_cell_size_estimator rcse_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_record_size (rsp_record_size)
);
